### design/msl_pkg.sv
// Package for the multi-servo slew limiter: beat structs, result kinds,
// and the microcode table that sequences the datapath.
// Depends on nothing; used by multi_servo_slew_limiter_top.
package msl_pkg;

  // Command codes carried in the cmd field.
  localparam logic [1:0] CmdSet     = 2'd0;
  localparam logic [1:0] CmdTick    = 2'd1;
  localparam logic [1:0] CmdGet     = 2'd2;
  localparam logic [1:0] CmdUnknown = 2'd3;

  // Result kinds.
  localparam logic [1:0] KindOk      = 2'd0;
  localparam logic [1:0] KindFmtErr  = 2'd1;
  localparam logic [1:0] KindUnknown = 2'd2;
  localparam logic [1:0] KindReport  = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgStepSize = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDeadBand = 2'd1;

  // Field widths.
  localparam int unsigned PosW   = 12;
  localparam int unsigned StepW  = 12;
  localparam int unsigned DeadW  = 4;
  localparam int unsigned AngleW = 8;

  localparam logic [PosW-1:0]   PosReset   = 12'd1440;
  localparam logic [AngleW-1:0] AngleReset = 8'd90;
  localparam logic [AngleW-1:0] AngleMax   = 8'd180;
  localparam logic [StepW-1:0]  StepReset  = 12'd8;
  localparam logic [DeadW-1:0]  DeadReset  = 4'd1;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [2:0]        channel;
    logic [AngleW-1:0] angle;
  } req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] servo;
    logic [7:0] degrees;
    logic       last;
  } rsp_t;

  // Microprogram addresses.
  localparam int unsigned PcW = 3;
  localparam logic [PcW-1:0] PcIdle    = 3'd0;
  localparam logic [PcW-1:0] PcSet     = 3'd1;
  localparam logic [PcW-1:0] PcTick    = 3'd2;
  localparam logic [PcW-1:0] PcReport  = 3'd3;
  localparam logic [PcW-1:0] PcUnknown = 3'd4;
  localparam logic [PcW-1:0] PcTickEnd = 3'd5;

  // Datapath operations.
  localparam logic [2:0] OpDispatch = 3'd0;
  localparam logic [2:0] OpSet      = 3'd1;
  localparam logic [2:0] OpTick     = 3'd2;
  localparam logic [2:0] OpReport   = 3'd3;
  localparam logic [2:0] OpUnknown  = 3'd4;
  localparam logic [2:0] OpNop      = 3'd5;

  // Branch conditions: taken goes to jmp, otherwise to alt.
  localparam logic [1:0] CondAlways = 2'd0;
  localparam logic [1:0] CondStart  = 2'd1;
  localparam logic [1:0] CondLast   = 2'd2;
  localparam logic [1:0] CondMoved  = 2'd3;

  typedef struct packed {
    logic [2:0]     op;
    logic [1:0]     cond;
    logic [PcW-1:0] jmp;
    logic [PcW-1:0] alt;
  } ucode_t;

  // Control store. The dispatch step adds the command code to its jump
  // target, so set, tick, get and unknown land on consecutive words.
  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t w;
    unique case (pc)
      PcIdle:    w = '{op: OpDispatch, cond: CondStart,  jmp: PcSet,     alt: PcIdle};
      PcSet:     w = '{op: OpSet,      cond: CondAlways, jmp: PcIdle,    alt: PcIdle};
      PcTick:    w = '{op: OpTick,     cond: CondLast,   jmp: PcTickEnd, alt: PcTick};
      PcReport:  w = '{op: OpReport,   cond: CondLast,   jmp: PcIdle,    alt: PcReport};
      PcUnknown: w = '{op: OpUnknown,  cond: CondAlways, jmp: PcIdle,    alt: PcIdle};
      PcTickEnd: w = '{op: OpNop,      cond: CondMoved,  jmp: PcReport,  alt: PcIdle};
      default:   w = '{op: OpNop,      cond: CondAlways, jmp: PcIdle,    alt: PcIdle};
    endcase
    return w;
  endfunction

endpackage

### design/multi_servo_slew_limiter_top.sv
// Multi-servo slew limiter: microcoded sequencer with per-channel state.
// Depends on msl_pkg for beat structs, codes and the control store.
//
// Usage:
//   Commands enter on req_i; a beat is taken at a clock edge where start_i
//   is high and busy_o is low. Results leave on res_o, each valid for one
//   cycle while res_valid_o is high; the receiver cannot stall them, and the
//   final result of a command carries last.
//   Configuration beats arrive on cfg_valid_i/cfg_ready_o with cfg_index_i
//   (0 step size, 1 dead band) and cfg_data_i; other indexes are dropped.
// Sequencing:
//   One control word executes per cycle. Set and unknown commands run the
//   dispatch word, then their own; get walks all channels in the report
//   word; a tick walks them in the tick word, then the tick-end word and,
//   if any moved, the report word. Results come from a registered output,
//   one step late; the channels share one move unit, taken one per cycle.
// Reset:
//   Positions return to 90 degrees, targets to 90, step size to 8 and dead
//   band to 1; the sequencer returns to its idle word.
module multi_servo_slew_limiter_top
  import msl_pkg::*;
#(
  parameter int unsigned NUM_SERVOS = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  req_t                  req_i,
  output logic                  busy_o,
  output logic                  res_valid_o,
  output rsp_t                  res_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [StepW-1:0]      cfg_data_i
);

  localparam int unsigned IdxW = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SERVOS - 1);
  localparam logic [4:0] NumServos5 = 5'(NUM_SERVOS);

  // Sequencer state.
  logic [PcW-1:0]  pc_q, pc_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            moved_q, moved_d;
  req_t            item_q;

  // Channel state and configuration.
  logic [PosW-1:0]   pos_q [NUM_SERVOS];
  logic [AngleW-1:0] tgt_q [NUM_SERVOS];
  logic [StepW-1:0]  step_q;
  logic [DeadW-1:0]  dead_q;

  // Output register.
  logic res_valid_q, res_valid_d;
  rsp_t res_q, res_d;

  ucode_t uw;
  logic   accept;
  logic   last_ch;
  logic   cond_ok;
  logic   set_ok;

  // Move unit signals.
  logic [PosW-1:0]        cur_pos;
  logic [AngleW-1:0]      cur_tgt;
  logic signed [PosW+1:0] diff;
  logic signed [PosW+1:0] mag;
  logic signed [PosW+1:0] lim;
  logic signed [PosW+1:0] mv;
  logic [PosW-1:0]        new_pos;
  logic                   outside;
  logic [PosW:0]          round_sum;
  logic [IdxW-1:0]        set_idx;

  assign uw          = ucode_rom(pc_q);
  assign busy_o      = (pc_q != PcIdle);
  assign accept      = start_i && !busy_o;
  assign last_ch     = (idx_q == LastIdx);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Condition select for the branch at the end of each step.
  always_comb begin
    case (uw.cond)
      CondAlways: cond_ok = 1'b1;
      CondStart:  cond_ok = accept;
      CondLast:   cond_ok = last_ch;
      CondMoved:  cond_ok = moved_q;
      default:    cond_ok = 1'b0;
    endcase
  end

  // Move unit: distance to target, dead-band test and clamp to the step.
  assign cur_pos = pos_q[idx_q];
  assign cur_tgt = tgt_q[idx_q];
  assign diff    = $signed({2'b00, cur_tgt, 4'b0000}) - $signed({2'b00, cur_pos});
  assign mag     = (diff < 0) ? -diff : diff;
  assign outside = (mag > $signed({{(PosW + 2 - DeadW){1'b0}}, dead_q}));
  assign lim     = $signed({2'b00, step_q});

  always_comb begin
    if (diff > lim) begin
      mv = lim;
    end else if (diff < -lim) begin
      mv = -lim;
    end else begin
      mv = diff;
    end
  end

  assign new_pos   = PosW'($signed({2'b00, cur_pos}) + mv);
  assign round_sum = {1'b0, cur_pos} + (PosW + 1)'(8);
  assign set_ok    = ({2'b00, item_q.channel} < NumServos5) && (item_q.angle <= AngleMax);
  assign set_idx   = IdxW'(item_q.channel);

  // Next step, channel counter, moved flag and the result beat.
  always_comb begin
    pc_d        = cond_ok ? uw.jmp : uw.alt;
    idx_d       = idx_q;
    moved_d     = moved_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    unique case (uw.op)
      OpDispatch: begin
        if (accept) begin
          pc_d = uw.jmp + PcW'(req_i.cmd);
        end
        idx_d   = '0;
        moved_d = 1'b0;
      end
      OpSet: begin
        res_valid_d = 1'b1;
        res_d.last  = 1'b1;
        if (set_ok) begin
          res_d.kind  = KindOk;
          res_d.servo = item_q.channel;
        end else begin
          res_d.kind = KindFmtErr;
        end
      end
      OpTick: begin
        idx_d = last_ch ? '0 : idx_q + 1'b1;
        if (outside) begin
          moved_d = 1'b1;
        end
      end
      OpReport: begin
        idx_d         = last_ch ? '0 : idx_q + 1'b1;
        res_valid_d   = 1'b1;
        res_d.kind    = KindReport;
        res_d.servo   = 3'(idx_q);
        res_d.degrees = round_sum[PosW-1:4];
        res_d.last    = last_ch;
      end
      OpUnknown: begin
        res_valid_d = 1'b1;
        res_d.kind  = KindUnknown;
        res_d.last  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PcIdle;
      idx_q       <= '0;
      moved_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      idx_q       <= idx_d;
      moved_q     <= moved_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Result payload and the latched command beat.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      item_q <= req_i;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepReset;
      dead_q <= DeadReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgStepSize) begin
        step_q <= cfg_data_i;
      end else if (cfg_index_i == CfgDeadBand) begin
        dead_q <= cfg_data_i[DeadW-1:0];
      end
    end
  end

  // Per-channel positions and targets.
  for (genvar g = 0; g < NUM_SERVOS; g++) begin : g_ch
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pos_q[g] <= PosReset;
        tgt_q[g] <= AngleReset;
      end else begin
        if (uw.op == OpTick && idx_q == IdxW'(g) && outside) begin
          pos_q[g] <= new_pos;
        end
        if (uw.op == OpSet && set_ok && set_idx == IdxW'(g)) begin
          tgt_q[g] <= item_q.angle;
        end
      end
    end
  end

`ifndef SYNTHESIS
  // The channel counter is back at zero whenever the sequencer idles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == PcIdle) |-> (idx_q == '0))
    else $error("channel counter not cleared at idle");

  // An accepted command always leaves the idle word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("command accepted but sequencer stayed idle");

  // A set command answers with a single final result once its set word has run and the output register holds it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.cmd == CmdSet) |=> ##1 (res_valid_o && res_o.last))
    else $error("set command gave no single result");

  // Anything but a position report is a single, final beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind != KindReport) |-> res_o.last)
    else $error("non-report result without last");

  // A report beat that is not last is followed by the next channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == KindReport && !res_o.last) |=>
      (res_valid_o && res_o.kind == KindReport &&
       res_o.servo == $past(res_o.servo) + 3'd1))
    else $error("report sequence broken");
`endif

endmodule

### bench/multi_servo_slew_limiter_top_tb.sv
`timescale 1ns / 1ps
// Testbench for multi_servo_slew_limiter_top: sends set, tick, get and unknown
// commands with random gaps, writes the step and dead band registers between
// phases, and checks every result beat against its own model of the limiter.
// Depends on msl_pkg and the design top only.
module multi_servo_slew_limiter_top_tb
  import msl_pkg::*;
();

  localparam int unsigned Servos       = 6;
  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned SettleCycles = 24;

  // Register indexes that the block has no register for.
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  req_t               req_i;
  logic               busy_o;
  logic               res_valid_o;
  rsp_t               res_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [StepW-1:0]   cfg_data_i;

  multi_servo_slew_limiter_top #(
    .NUM_SERVOS(Servos)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow copy of the limiter state and its registers.
  logic [PosW-1:0]   shadow_pos    [Servos];
  logic [AngleW-1:0] shadow_target [Servos];
  logic [StepW-1:0]  shadow_step;
  logic [DeadW-1:0]  shadow_dead;

  rsp_t pending_results[$];

  int  mismatch_count;
  int  commands_sent;
  int  results_checked;
  int  quiet_ticks;
  int  settings_used;
  int  idle_cycles;
  bit  no_gaps;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic reset_shadow();
    for (int i = 0; i < Servos; i++) begin
      shadow_pos[i]    = PosReset;
      shadow_target[i] = AngleReset;
    end
    shadow_step = StepReset;
    shadow_dead = DeadReset;
  endtask

  // Queue one position report: every channel, rounded half up to degrees.
  task automatic expect_positions();
    logic [PosW:0] rounded;
    for (int i = 0; i < Servos; i++) begin
      rounded = {1'b0, shadow_pos[i]} + (PosW + 1)'(8);
      pending_results.push_back('{kind: KindReport, servo: 3'(i),
                                  degrees: rounded[PosW-1:4],
                                  last: (i == Servos - 1)});
    end
  endtask

  // Update the shadow state for one accepted command and queue its results.
  task automatic apply_command(input req_t r);
    int diff;
    int mag;
    int move;
    bit moved;
    moved = 1'b0;
    case (r.cmd)
      CmdSet: begin
        if (r.channel < Servos && r.angle <= AngleMax) begin
          shadow_target[r.channel] = r.angle;
          pending_results.push_back('{kind: KindOk, servo: r.channel,
                                      degrees: '0, last: 1'b1});
        end else begin
          pending_results.push_back('{kind: KindFmtErr, servo: '0,
                                      degrees: '0, last: 1'b1});
        end
      end
      CmdTick: begin
        for (int i = 0; i < Servos; i++) begin
          diff = int'(shadow_target[i]) * 16 - int'(shadow_pos[i]);
          mag  = (diff < 0) ? -diff : diff;
          if (mag > int'(shadow_dead)) begin
            move = diff;
            if (move > int'(shadow_step)) move = int'(shadow_step);
            if (move < -int'(shadow_step)) move = -int'(shadow_step);
            shadow_pos[i] = PosW'(int'(shadow_pos[i]) + move);
            moved = 1'b1;
          end
        end
        if (moved) expect_positions();
        else quiet_ticks++;
      end
      CmdGet: expect_positions();
      default: begin
        pending_results.push_back('{kind: KindUnknown, servo: '0,
                                    degrees: '0, last: 1'b1});
      end
    endcase
  endtask

  function automatic req_t make_req(input logic [1:0] cmd, input int channel,
                                    input int angle);
    req_t r;
    r.cmd     = cmd;
    r.channel = 3'(channel);
    r.angle   = AngleW'(angle);
    return r;
  endfunction

  // Random command: mostly ticks and valid sets, some reads, bad sets and
  // unknown codes. Unused fields carry random bits.
  function automatic req_t random_request();
    req_t r;
    int   pick;
    pick      = $urandom_range(0, 99);
    r.channel = 3'($urandom_range(0, 7));
    r.angle   = AngleW'($urandom_range(0, 255));
    if (pick < 40) begin
      r.cmd = CmdTick;
    end else if (pick < 75) begin
      r.cmd     = CmdSet;
      r.channel = 3'($urandom_range(0, Servos - 1));
      case ($urandom_range(0, 7))
        0:       r.angle = '0;
        1:       r.angle = AngleMax;
        default: r.angle = AngleW'($urandom_range(0, 180));
      endcase
    end else if (pick < 85) begin
      r.cmd = CmdGet;
    end else if (pick < 95) begin
      r.cmd = CmdSet;
      if ($urandom_range(0, 1)) r.channel = 3'($urandom_range(Servos, 7));
      else r.angle = AngleW'($urandom_range(181, 255));
    end else begin
      r.cmd = CmdUnknown;
    end
    return r;
  endfunction

  // Send one command beat. Start stays high when the next beat follows at once.
  task automatic send_command(input req_t r);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    apply_command(r);
    commands_sent++;
  endtask

  // Stop sending, let every expected result drain and the sequencer settle.
  task automatic drain_block();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
  endtask

  // Write both registers back to back, optionally with writes to unused
  // indexes around them that the block must drop.
  task automatic write_registers(input logic [StepW-1:0] step,
                                 input logic [StepW-1:0] dead_raw,
                                 input bit with_spare);
    logic [CfgIdxW-1:0] idx_q[$];
    logic [StepW-1:0]   data_q[$];
    if (with_spare) begin
      idx_q.push_back(CfgSpareA);
      data_q.push_back(StepW'($urandom));
    end
    idx_q.push_back(CfgStepSize);
    data_q.push_back(step);
    idx_q.push_back(CfgDeadBand);
    data_q.push_back(dead_raw);
    if (with_spare) begin
      idx_q.push_back(CfgSpareB);
      data_q.push_back(StepW'($urandom));
    end
    foreach (idx_q[k]) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx_q[k];
      cfg_data_i  <= data_q[k];
      do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
      case (idx_q[k])
        CfgStepSize: shadow_step = data_q[k];
        CfgDeadBand: shadow_dead = data_q[k][DeadW-1:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Reset defaults: a read, a quiet tick, each kind of bad command, extreme
  // targets and the first slow moves.
  task automatic test_reset_defaults();
    send_command(make_req(CmdGet, 0, 0));
    send_command(make_req(CmdTick, 0, 0));
    send_command(make_req(CmdSet, 6, 10));
    send_command(make_req(CmdSet, 7, 0));
    send_command(make_req(CmdSet, 0, 181));
    send_command(make_req(CmdSet, 2, 255));
    send_command(make_req(CmdUnknown, 7, 255));
    send_command(make_req(CmdSet, 0, 0));
    send_command(make_req(CmdSet, 5, 180));
    send_command(make_req(CmdTick, 0, 0));
    send_command(make_req(CmdTick, 5, 170));
  endtask

  // Largest step and no dead band: channels jump straight to their targets.
  task automatic test_full_step();
    drain_block();
    write_registers('1, '0, 1'b1);
    send_command(make_req(CmdTick, 0, 0));
    send_command(make_req(CmdSet, 1, 1));
    send_command(make_req(CmdTick, 0, 0));
    send_command(make_req(CmdGet, 0, 0));
  endtask

  // Zero step: a channel outside the band reports movement but stays put.
  task automatic test_zero_step();
    drain_block();
    write_registers('0, '1, 1'b1);
    send_command(make_req(CmdSet, 3, 100));
    send_command(make_req(CmdTick, 0, 0));
    send_command(make_req(CmdGet, 0, 0));
  endtask

  // Widest dead band with unit step: a distance of 16 moves once, then 15
  // is inside the band and the tick stays quiet.
  task automatic test_dead_band_edge();
    drain_block();
    write_registers(StepW'(1), StepW'(15), 1'b0);
    send_command(make_req(CmdSet, 3, 90));
    send_command(make_req(CmdSet, 4, 91));
    send_command(make_req(CmdTick, 0, 0));
    send_command(make_req(CmdTick, 0, 0));
  endtask

  task automatic test_random_traffic(input logic [StepW-1:0] step,
                                     input logic [StepW-1:0] dead_raw,
                                     input int count, input bit back_to_back);
    drain_block();
    write_registers(step, dead_raw, 1'($urandom_range(0, 1)));
    no_gaps = back_to_back;
    repeat (count) send_command(random_request());
    no_gaps = 1'b0;
  endtask

  // Each result beat is compared with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    rsp_t want;
    if (rst_ni && res_valid_o !== 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %p", res_o));
      end else begin
        want = pending_results.pop_front();
        if (res_o.kind !== want.kind || res_o.servo !== want.servo ||
            res_o.degrees !== want.degrees || res_o.last !== want.last) begin
          report_mismatch($sformatf(
            "result %0d got kind %0d servo %0d degrees %0d last %0b, expected %0d %0d %0d %0b",
            results_checked, res_o.kind, res_o.servo, res_o.degrees, res_o.last,
            want.kind, want.servo, want.degrees, want.last));
        end
        results_checked++;
      end
    end
  end

  // Watchdog: ends the run when no beat of any kind moves for too long.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Timeout: no beat for %0d cycles, %0d results outstanding.",
               IdleLimit, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    no_gaps     = 1'b0;
    reset_shadow();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_full_step();
    test_zero_step();
    test_dead_band_edge();
    test_random_traffic(StepW'(2880), StepW'(0), 60, 1'b0);
    test_random_traffic(StepW'($urandom_range(1, 64)), StepW'($urandom), 60, 1'b1);
    test_random_traffic(StepW'(1), StepW'(15), 50, 1'b0);
    test_random_traffic(StepW'($urandom_range(0, 4095)), StepW'($urandom), 60, 1'b0);
    test_random_traffic(StepW'($urandom_range(1, 300)), StepW'($urandom), 70, 1'b0);
    test_random_traffic('1, StepW'(12'hFF0), 60, 1'b1);
    drain_block();

    $display("Run covered %0d commands, %0d result beats, %0d quiet ticks,",
             commands_sent, results_checked, quiet_ticks);
    $display("over %0d register settings, with %0d mismatches.",
             settings_used, mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
